// ----- rtl/adpcm_pkg.sv -----
package adpcm_pkg;

	localparam int NUM_PAIRS   = 8;
	localparam int PAIR_SEL_W  = 3;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 32;
	localparam int COEF_W      = 16;
	localparam int SAMPLE_W    = 16;
	localparam int POS_W       = 3;
	localparam int SHIFT_W     = 4;
	localparam int NIBBLE_W    = 4;
	localparam int FRAC_BITS   = 11;
	localparam int ACC_W       = 34;
	localparam int HALF_ROUND  = 'h400;
	localparam int PROD_W      = 2 * COEF_W;
	localparam int Y_W         = ACC_W - FRAC_BITS;

	localparam logic signed [SAMPLE_W-1:0] SAT_HI = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAT_LO = 16'sh8000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_DONE
	} state_t;

	// Control of the shared multiply-accumulate unit.
	typedef struct packed {
		logic en;
		logic load;
	} mac_ctrl_t;

	// Floor division by 2^FRAC_BITS, then saturation to the 16-bit range.
	function automatic logic signed [SAMPLE_W-1:0] sat_sample(
		input logic signed [ACC_W-1:0] acc
	);
		logic signed [Y_W-1:0] y;
		logic signed [SAMPLE_W-1:0] res;
		begin
			y = acc[ACC_W-1:FRAC_BITS];
			if (y > Y_W'(SAT_HI)) begin
				res = SAT_HI;
			end else if (y < Y_W'(SAT_LO)) begin
				res = SAT_LO;
			end else begin
				res = y[SAMPLE_W-1:0];
			end
			return res;
		end
	endfunction

endpackage

// ----- rtl/adpcm_coef_regs.sv -----
module adpcm_coef_regs (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [adpcm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [adpcm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [adpcm_pkg::PAIR_SEL_W-1:0]      sel,
	output logic signed [adpcm_pkg::COEF_W-1:0]   coef1,
	output logic signed [adpcm_pkg::COEF_W-1:0]   coef2
);
	import adpcm_pkg::*;

	logic [CFG_DATA_W-1:0] pairs_q [NUM_PAIRS];
	logic                  wr_hit;

	// Writes to indexes beyond the last pair are dropped.
	assign wr_hit = cfg_we && (cfg_index < CFG_IDX_W'(NUM_PAIRS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PAIRS; i++) begin
				pairs_q[i] <= '0;
			end
		end else if (wr_hit) begin
			pairs_q[cfg_index[PAIR_SEL_W-1:0]] <= cfg_data;
		end
	end

	assign coef1 = pairs_q[sel][COEF_W-1:0];
	assign coef2 = pairs_q[sel][2*COEF_W-1:COEF_W];

endmodule

// ----- rtl/adpcm_mac.sv -----
module adpcm_mac (
	input  logic                                  clk,
	input  adpcm_pkg::mac_ctrl_t                  ctrl,
	input  logic [adpcm_pkg::NIBBLE_W-1:0]        nibble,
	input  logic [adpcm_pkg::SHIFT_W-1:0]         shift,
	input  logic signed [adpcm_pkg::COEF_W-1:0]   coef,
	input  logic signed [adpcm_pkg::SAMPLE_W-1:0] hist,
	output logic signed [adpcm_pkg::ACC_W-1:0]    acc
);
	import adpcm_pkg::*;

	logic signed [ACC_W-1:0]  xn_ext;
	logic signed [ACC_W-1:0]  base;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  acc_q;

	// Scaled residual with its rounding constant, already in the 11-bit fraction.
	assign xn_ext = ACC_W'(signed'(nibble));
	assign base   = ((xn_ext <<< shift) <<< FRAC_BITS) + ACC_W'(HALF_ROUND);
	assign prod   = coef * hist;

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			acc_q <= (ctrl.load ? base : acc_q) + ACC_W'(prod);
		end
	end

	assign acc = acc_q;

endmodule

// ----- rtl/adpcm_4bit_frame_decoder_top.sv -----
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------------
// input    | in_valid / in_stall  | data_byte, buffer_start, clear_history, only_low_nibble
// output   | out_valid / out_stall| sample, last_of_byte
// config   | cfg_we               | cfg_index, cfg_data
//
// A header byte is taken without leaving the idle state and yields no transfer on the output.
// A data byte is taken in the idle state, and no further byte is taken until its samples
// are done; each sample runs through ST_MUL1, ST_MUL2 and ST_DONE, as the two multiplies
// per sample share the one 16x16 multiplier and ST_DONE saturates and registers the result.
// Reset clears the coefficient pairs, frame position, scale, predictor choice and history.
// A stalled output holds the sequencer at its final step until the held sample is taken.
module adpcm_4bit_frame_decoder_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [7:0]                            data_byte,
	input  logic                                  buffer_start,
	input  logic                                  clear_history,
	input  logic                                  only_low_nibble,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [adpcm_pkg::SAMPLE_W-1:0] sample,
	output logic                                  last_of_byte,
	input  logic                                  cfg_we,
	input  logic [adpcm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [adpcm_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import adpcm_pkg::*;

	state_t state_q, state_d;
	mac_ctrl_t mac_ctrl;

	logic [7:0]                  byte_q;
	logic                        low_only_q;
	logic                        nib_sel_q;
	logic [SHIFT_W-1:0]          shift_q;
	logic [PAIR_SEL_W-1:0]       sel_q;
	logic [POS_W-1:0]            pos_q;
	logic signed [SAMPLE_W-1:0]  h1_q;
	logic signed [SAMPLE_W-1:0]  h2_q;
	logic                        out_valid_q;
	logic signed [SAMPLE_W-1:0]  sample_q;
	logic                        last_q;

	logic                        in_xfer;
	logic                        is_header;
	logic                        out_free;
	logic                        last_now;
	logic                        emit;
	logic [NIBBLE_W-1:0]         nibble;
	logic signed [COEF_W-1:0]    coef1, coef2, mac_coef;
	logic signed [SAMPLE_W-1:0]  mac_hist;
	logic signed [ACC_W-1:0]     acc;
	logic signed [SAMPLE_W-1:0]  y;

	// A byte is a header when flagged so, or when the frame is waiting for one.
	assign in_xfer   = in_valid && !in_stall;
	assign is_header = buffer_start || (pos_q == '0);

	// The output register may be loaded when empty or when its sample leaves now.
	assign out_free  = !out_valid_q || !out_stall;
	assign last_now  = low_only_q || nib_sel_q;
	assign emit      = (state_q == ST_DONE) && out_free;

	assign nibble    = nib_sel_q ? byte_q[7:4] : byte_q[3:0];
	assign mac_coef  = (state_q == ST_MUL2) ? coef2 : coef1;
	assign mac_hist  = (state_q == ST_MUL2) ? h2_q : h1_q;
	assign y         = sat_sample(acc);

	adpcm_coef_regs u_coef_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sel       (sel_q),
		.coef1     (coef1),
		.coef2     (coef2)
	);

	// First pass loads the scaled residual plus coef1 * y[n-1], the second adds coef2 * y[n-2].
	adpcm_mac u_mac (
		.clk    (clk),
		.ctrl   (mac_ctrl),
		.nibble (nibble),
		.shift  (shift_q),
		.coef   (mac_coef),
		.hist   (mac_hist),
		.acc    (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		mac_ctrl = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && !is_header) begin
					state_d = ST_MUL1;
				end
			end
			ST_MUL1: begin
				mac_ctrl.en   = 1'b1;
				mac_ctrl.load = 1'b1;
				state_d       = ST_MUL2;
			end
			ST_MUL2: begin
				mac_ctrl.en = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = last_now ? ST_IDLE : ST_MUL1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q      <= '0;
			low_only_q  <= 1'b0;
			nib_sel_q   <= 1'b0;
			shift_q     <= '0;
			sel_q       <= '0;
			pos_q       <= '0;
			h1_q        <= '0;
			h2_q        <= '0;
			out_valid_q <= 1'b0;
			sample_q    <= '0;
			last_q      <= 1'b0;
		end else begin
			if (in_xfer) begin
				// The history clear applies to headers as well as data bytes.
				if (clear_history) begin
					h1_q <= '0;
					h2_q <= '0;
				end
				if (is_header) begin
					shift_q <= data_byte[SHIFT_W-1:0];
					sel_q   <= data_byte[SHIFT_W+PAIR_SEL_W-1:SHIFT_W];
					pos_q   <= POS_W'(1);
				end else begin
					pos_q      <= pos_q + POS_W'(1);
					byte_q     <= data_byte;
					low_only_q <= only_low_nibble;
					nib_sel_q  <= 1'b0;
				end
			end
			if (emit) begin
				h2_q        <= h1_q;
				h1_q        <= y;
				sample_q    <= y;
				last_q      <= last_now;
				out_valid_q <= 1'b1;
				nib_sel_q   <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign sample       = sample_q;
	assign last_of_byte = last_q;

endmodule

// ----- rtl/adpcm_chk.sv -----
module adpcm_chk (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_stall,
	input logic                                  buffer_start,
	input logic                                  out_valid,
	input logic                                  out_stall,
	input logic signed [adpcm_pkg::SAMPLE_W-1:0] sample,
	input logic                                  last_of_byte
);

	// Nothing is offered on the output once reset has been seen at a clock edge.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

	// A held sample stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample) && $stable(last_of_byte))
		else $error("stalled output changed");

	// A header flagged by buffer_start is taken and the block is ready again in the next cycle.
	a_header_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && buffer_start |=> !in_stall)
		else $error("not ready after header");

	// While the first sample of a pair is on show, the byte is still being worked on.
	a_pair_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_byte |-> in_stall)
		else $error("ready while a byte is unfinished");

endmodule

bind adpcm_4bit_frame_decoder_top adpcm_chk u_adpcm_chk (.*);

// ----- verif/adpcm_decode_checker.sv -----
// Watches the byte and sample channels of the ADPCM frame decoder, keeps its own
// copy of the decoder state and coefficient pairs, and checks every sample transfer
// against the oldest predicted sample.
module adpcm_decode_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic [7:0]                            data_byte,
	input  logic                                  buffer_start,
	input  logic                                  clear_history,
	input  logic                                  only_low_nibble,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic signed [adpcm_pkg::SAMPLE_W-1:0] sample,
	input  logic                                  last_of_byte,
	input  logic                                  cfg_we,
	input  logic [adpcm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [adpcm_pkg::CFG_DATA_W-1:0]      cfg_data,
	output int                                    fail_count,
	output int                                    pending
);
	import adpcm_pkg::*;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] pcm;
		logic                       is_last;
	} pcm_item_t;

	pcm_item_t pcm_due_q[$];

	logic [CFG_DATA_W-1:0]      pair_copy [NUM_PAIRS];
	logic [POS_W-1:0]           frame_pos;
	logic [SHIFT_W-1:0]         shift_amt;
	logic [PAIR_SEL_W-1:0]      pair_sel;
	logic signed [SAMPLE_W-1:0] hist_one;
	logic signed [SAMPLE_W-1:0] hist_two;

	pcm_item_t                  due;
	logic signed [SAMPLE_W-1:0] pcm;

	// One decoded sample from the current scale, predictor and history.
	function automatic logic signed [SAMPLE_W-1:0] decode_pcm(input logic [NIBBLE_W-1:0] nib);
		logic signed [NIBBLE_W-1:0] nib_s;
		logic signed [COEF_W-1:0]   c1_s;
		logic signed [COEF_W-1:0]   c2_s;
		logic signed [63:0]         xn;
		logic signed [63:0]         c1;
		logic signed [63:0]         c2;
		logic signed [63:0]         h1;
		logic signed [63:0]         h2;
		logic signed [63:0]         acc;
		logic signed [63:0]         y;
		nib_s = nib;
		xn = nib_s;
		xn = xn <<< shift_amt;
		c1_s = pair_copy[pair_sel][COEF_W-1:0];
		c2_s = pair_copy[pair_sel][2*COEF_W-1:COEF_W];
		c1 = c1_s;
		c2 = c2_s;
		h1 = hist_one;
		h2 = hist_two;
		acc = (xn <<< FRAC_BITS) + 64'sd1024 + c1 * h1 + c2 * h2;
		// An arithmetic shift gives the floor of the division.
		y = acc >>> FRAC_BITS;
		if (y > 64'sd32767) begin
			return SAT_HI;
		end else if (y < -64'sd32768) begin
			return SAT_LO;
		end
		return y[SAMPLE_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcm_due_q.delete();
			for (int k = 0; k < NUM_PAIRS; k++) begin
				pair_copy[k] = '0;
			end
			frame_pos = '0;
			shift_amt = '0;
			pair_sel = '0;
			hist_one = '0;
			hist_two = '0;
			fail_count = 0;
			pending = 0;
		end else begin
			// Outputs first: a sample leaving now never belongs to a byte taken now.
			if (out_valid && !out_stall) begin
				if (pcm_due_q.size() == 0) begin
					$error("sample: expected none, actual %0d", sample);
					fail_count++;
				end else begin
					due = pcm_due_q.pop_front();
					if (sample !== due.pcm) begin
						$error("sample: expected %0d, actual %0d", due.pcm, sample);
						fail_count++;
					end
					if (last_of_byte !== due.is_last) begin
						$error("last_of_byte: expected %0b, actual %0b", due.is_last,
							last_of_byte);
						fail_count++;
					end
				end
			end
			if (cfg_we && cfg_index < NUM_PAIRS) begin
				pair_copy[cfg_index[PAIR_SEL_W-1:0]] = cfg_data;
			end
			if (in_valid && !in_stall) begin
				if (clear_history) begin
					hist_one = '0;
					hist_two = '0;
				end
				if (buffer_start || frame_pos == 0) begin
					shift_amt = data_byte[3:0];
					pair_sel = data_byte[6:4];
					frame_pos = POS_W'(1);
				end else begin
					frame_pos = frame_pos + 1'b1;
					pcm = decode_pcm(data_byte[3:0]);
					hist_two = hist_one;
					hist_one = pcm;
					pcm_due_q.push_back('{pcm: pcm, is_last: only_low_nibble});
					if (!only_low_nibble) begin
						pcm = decode_pcm(data_byte[7:4]);
						hist_two = hist_one;
						hist_one = pcm;
						pcm_due_q.push_back('{pcm: pcm, is_last: 1'b1});
					end
				end
			end
			pending = pcm_due_q.size();
		end
	end

endmodule

// ----- verif/tb_top.sv -----
// Stimulus and verdict for the ADPCM frame decoder. The checker beside the block does
// all prediction and comparison; this module only makes traffic and decides the result.
module tb_top;
	import adpcm_pkg::*;

	// A data byte passes only through the multiply and done states of the block, so this
	// comfortably covers any sample still in flight once the checker has nothing outstanding.
	localparam int DRAIN_WAIT     = 16;
	// Longest quiet stretch is the deliberate receiver hold-off below.
	localparam int HOLD_OFF       = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 400;

	// Coefficient pairs for the directed part: unity, a typical stable pair, the
	// largest and most negative coefficients, and minus one least significant bit.
	localparam logic [CFG_DATA_W-1:0] DIRECTED_PAIRS [NUM_PAIRS] = '{
		32'h0000_0000, 32'h0000_0800, 32'hFC00_0F00, 32'h7FFF_7FFF,
		32'h8000_8000, 32'hFFFF_FFFF, 32'hF900_0E00, 32'h0400_F800
	};
	// The corners of the coefficient range, used for one whole random phase.
	localparam logic [CFG_DATA_W-1:0] CORNER_PAIRS [NUM_PAIRS] = '{
		32'h7FFF_7FFF, 32'h8000_8000, 32'h7FFF_8000, 32'h8000_7FFF,
		32'h0000_7FFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0001
	};

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [7:0]                 data_byte;
	logic                       buffer_start;
	logic                       clear_history;
	logic                       only_low_nibble;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last_of_byte;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_data;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	adpcm_4bit_frame_decoder_top dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.buffer_start    (buffer_start),
		.clear_history   (clear_history),
		.only_low_nibble (only_low_nibble),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sample          (sample),
		.last_of_byte    (last_of_byte),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	adpcm_decode_checker pcm_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.buffer_start    (buffer_start),
		.clear_history   (clear_history),
		.only_low_nibble (only_low_nibble),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sample          (sample),
		.last_of_byte    (last_of_byte),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending         (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// The receiver decides its stall at each falling edge. A requested hold-off is
	// counted down here, one cycle at a time, before random stalling resumes.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Any transfer on either channel shows the block is alive; a long run with none
	// means it has hung.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Offers one byte and returns at the rising edge at which it is transferred. The
	// valid stays high with the old payload until the next falling edge, where the
	// next call or a pause replaces it.
	task automatic push_byte(input logic [7:0] b, input logic st, input logic clr,
		input logic lo);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		buffer_start <= st;
		clear_history <= clr;
		only_low_nibble <= lo;
		do begin
			@(posedge clk);
		end while (in_stall);
	endtask

	// Stops offering bytes and waits until every predicted sample has been
	// transferred, then lets the block settle before anything is reconfigured.
	task automatic settle_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_coef(input int idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly a stable predictor so that the history stays meaningful; now and then
	// a completely arbitrary pair that tends to saturate.
	function automatic logic [CFG_DATA_W-1:0] draw_pair();
		logic [COEF_W-1:0] c1;
		logic [COEF_W-1:0] c2;
		if ($urandom_range(3) == 0) begin
			return $urandom;
		end
		c1 = COEF_W'($urandom_range(4095));
		c2 = COEF_W'(-int'($urandom_range(2048)));
		return {c2, c1};
	endfunction

	// Writes all eight pairs and then one index above the last pair, which the
	// block must ignore.
	task automatic load_pairs(input int mode);
		logic [CFG_DATA_W-1:0] value;
		for (int k = 0; k < NUM_PAIRS; k++) begin
			case (mode)
				0: value = DIRECTED_PAIRS[k];
				1: value = CORNER_PAIRS[k];
				default: value = draw_pair();
			endcase
			write_coef(k, value);
		end
		write_coef($urandom_range(NUM_PAIRS, (1 << CFG_IDX_W) - 1), $urandom);
	endtask

	// Mostly whole frames with random content: a header, then seven data bytes or
	// a shorter buffer, and either may end in an odd tail. The rest is noise with
	// every flag random, which breaks frames at arbitrary points.
	task automatic random_stream(input int n_items, input bit pause_midway);
		int sent;
		int n_data;
		bit paused;
		sent = 0;
		paused = 1'b0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 85) begin
				push_byte(8'($urandom), $urandom_range(3) != 0, $urandom_range(15) == 0,
					1'($urandom_range(1)));
				n_data = ($urandom_range(7) == 0) ? $urandom_range(1, 6) : 7;
				for (int i = 1; i <= n_data; i++) begin
					push_byte(8'($urandom), 1'b0, $urandom_range(31) == 0,
						i == n_data && $urandom_range(3) == 0);
				end
				sent += n_data + 1;
			end else begin
				push_byte(8'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)),
					1'($urandom_range(1)));
				sent++;
			end
			// The sender goes quiet once until the output side has caught up.
			if (pause_midway && !paused && sent >= n_items / 2) begin
				settle_block();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		buffer_start = 1'b0;
		clear_history = 1'b0;
		only_low_nibble = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 18;
		recv_stall_pct = 79;
		load_pairs(0);

		// The very first byte has no start flag but is still a header, since the
		// frame position is at zero; the odd tail flag on it must be ignored.
		push_byte(8'h00, 1'b0, 1'b0, 1'b1);
		push_byte(8'h87, 1'b0, 1'b0, 1'b0);
		// Odd tail: only the low nibble is decoded and it ends the byte.
		push_byte(8'h7F, 1'b0, 1'b0, 1'b1);
		// A new buffer part-way through a frame, with bit 7 of the header set.
		push_byte(8'hCF, 1'b1, 1'b0, 1'b0);
		push_byte(8'h77, 1'b0, 1'b0, 1'b0);
		push_byte(8'h88, 1'b0, 1'b0, 1'b0);
		push_byte(8'h80, 1'b0, 1'b0, 1'b0);
		// Clearing the history on a header, then a full frame at the largest scale
		// with the largest coefficients, driving both saturation limits.
		push_byte(8'h3F, 1'b1, 1'b1, 1'b0);
		push_byte(8'h77, 1'b0, 1'b0, 1'b0);
		push_byte(8'h77, 1'b0, 1'b0, 1'b0);
		push_byte(8'h88, 1'b0, 1'b0, 1'b0);
		push_byte(8'h08, 1'b0, 1'b0, 1'b0);
		push_byte(8'hF0, 1'b0, 1'b0, 1'b0);
		push_byte(8'h0F, 1'b0, 1'b0, 1'b0);
		push_byte(8'h91, 1'b0, 1'b0, 1'b0);
		// The frame has wrapped, so this byte is a header without a start flag.
		push_byte(8'h5A, 1'b0, 1'b0, 1'b0);
		// Clearing the history on a data byte.
		push_byte(8'hA5, 1'b0, 1'b1, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0, 1'b0);
		push_byte(8'h62, 1'b1, 1'b0, 1'b0);
		push_byte(8'h1E, 1'b0, 1'b0, 1'b0);
		push_byte(8'hE1, 1'b0, 1'b0, 1'b0);
		push_byte(8'h44, 1'b0, 1'b0, 1'b1);
		push_byte(8'h10, 1'b1, 1'b0, 1'b0);
		push_byte(8'h11, 1'b0, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b0, 1'b0);
		settle_block();

		// Three random phases with different idling and a fresh set of pairs each,
		// the middle one at the corners of the coefficient range.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 18;
					recv_stall_pct = 79;
				end
				1: begin
					send_idle_pct = 79;
					recv_stall_pct = 18;
				end
				default: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			load_pairs(phase == 1 ? 1 : 2);
			if (phase == 2) begin
				// The receiver holds off for a long stretch while bytes keep coming,
				// so the block fills and stalls its input.
				@(posedge clk);
				hold_left = HOLD_OFF;
			end
			random_stream(PHASE_ITEMS, phase == 0);
			settle_block();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
